### hw/rtl/pgt_pkg.sv
// price gap tracker package: table sizing, count widths and the trim result type
// no dependencies
`default_nettype none
package pgt_pkg;

  localparam int GAP_SLOTS = 32;
  localparam int SLOT_W    = $clog2(GAP_SLOTS);
  localparam int CNT_W     = $clog2(GAP_SLOTS + 1);
  localparam int PRICE_W   = 32;
  localparam int TIME_W    = 48;

  localparam logic [1:0] GAP_NONE = 2'd0;
  localparam logic [1:0] GAP_UP   = 2'd1;
  localparam logic [1:0] GAP_DOWN = 2'd2;

  typedef struct packed {
    logic               cancel;
    logic [PRICE_W-1:0] lo;
    logic [PRICE_W-1:0] hi;
  } trim_res_t;

endpackage
`default_nettype wire

### hw/rtl/pgt_trim_unit.sv
// shared trim unit: applies one bar to one stored gap
// depends on pgt_pkg
`default_nettype none
module pgt_trim_unit (
  input  wire logic [pgt_pkg::PRICE_W-1:0] gap_lo,
  input  wire logic [pgt_pkg::PRICE_W-1:0] gap_hi,
  input  wire logic [pgt_pkg::PRICE_W-1:0] bar_lo,
  input  wire logic [pgt_pkg::PRICE_W-1:0] bar_hi,
  output pgt_pkg::trim_res_t               res
);

  logic inside_bar;
  logic cover_bar;
  logic low_part;
  logic up_part;

  assign inside_bar = (bar_lo > gap_lo) && (bar_hi < gap_hi);
  assign cover_bar  = (bar_lo <= gap_lo) && (bar_hi >= gap_hi);
  assign low_part   = (bar_lo <= gap_lo) && (bar_hi > gap_lo);
  assign up_part    = (bar_hi >= gap_hi) && (bar_lo < gap_hi);

  always_comb begin
    res.cancel = 1'b0;
    res.lo     = gap_lo;
    res.hi     = gap_hi;
    if (inside_bar || cover_bar) begin
      res.cancel = 1'b1;
    end else if (low_part) begin
      res.lo     = bar_hi;
      res.cancel = bar_hi >= gap_hi;
    end else if (up_part) begin
      res.hi     = bar_lo;
      res.cancel = gap_lo >= bar_lo;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/price_gap_tracker_core.sv
// price gap tracker top level: sequencer, gap table memory and gap detection
// depends on pgt_pkg and pgt_trim_unit
// a new bar is taken only in ST_IDLE, after the previous result is loaded into the output
// registers; each bar is scanned by the single trim unit walking the table one slot a cycle
// reset: synchronous, clears history, valid bits and min_height; table data is not cleared
`default_nettype none
module price_gap_tracker_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [31:0]                 cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [pgt_pkg::PRICE_W-1:0] in_bar_high,
  input  wire logic [pgt_pkg::PRICE_W-1:0] in_bar_low,
  input  wire logic [pgt_pkg::TIME_W-1:0]  in_bar_time,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_new_gap,
  output logic [pgt_pkg::PRICE_W-1:0]      out_new_gap_low,
  output logic [pgt_pkg::PRICE_W-1:0]      out_new_gap_high,
  output logic [pgt_pkg::TIME_W-1:0]       out_new_gap_time,
  output logic [pgt_pkg::CNT_W-1:0]        out_cancelled,
  output logic [pgt_pkg::CNT_W-1:0]        out_open_gaps,
  output logic                             out_overflow
);

  localparam int SW = pgt_pkg::SLOT_W;
  localparam int CW = pgt_pkg::CNT_W;
  localparam int PW = pgt_pkg::PRICE_W;
  localparam int TW = pgt_pkg::TIME_W;
  localparam logic [SW:0] SCAN_END = (SW+1)'(pgt_pkg::GAP_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DET_UP, ST_DET_DN, ST_INSERT, ST_FINISH
  } st_t;

  st_t st_r, st_nxt;

  logic [PW-1:0] min_height_r, min_height_nxt;
  logic [PW-1:0] older_high_r, older_high_nxt, older_low_r, older_low_nxt;
  logic [PW-1:0] prior_high_r, prior_high_nxt, prior_low_r, prior_low_nxt;
  logic [TW-1:0] prior_time_r, prior_time_nxt;
  logic [1:0]    bars_seen_r, bars_seen_nxt;
  logic [PW-1:0] bar_hi_r, bar_hi_nxt, bar_lo_r, bar_lo_nxt;
  logic [TW-1:0] bar_time_r, bar_time_nxt;

  logic [pgt_pkg::GAP_SLOTS-1:0] gap_valid_r, gap_valid_nxt;
  logic [SW:0]   cnt_r, cnt_nxt;
  logic          ev_en_r, ev_en_nxt;
  logic          ev_valid_r, ev_valid_nxt;
  logic [SW-1:0] ev_idx_r, ev_idx_nxt;
  logic          free_found_r, free_found_nxt;
  logic [SW-1:0] free_idx_r, free_idx_nxt;
  logic [CW-1:0] cancel_cnt_r, cancel_cnt_nxt, open_cnt_r, open_cnt_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [PW-1:0] nlo_r, nlo_nxt, nhi_r, nhi_nxt;
  logic          ovf_r, ovf_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_gap_r, out_gap_nxt;
  logic [PW-1:0] out_lo_r, out_lo_nxt, out_hi_r, out_hi_nxt;
  logic [TW-1:0] out_time_r, out_time_nxt;
  logic [CW-1:0] out_cancel_r, out_cancel_nxt, out_open_r, out_open_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic [PW-1:0] gap_lo_mem [pgt_pkg::GAP_SLOTS];
  logic [PW-1:0] gap_hi_mem [pgt_pkg::GAP_SLOTS];
  logic [PW-1:0] rd_lo_r, rd_hi_r;
  logic [SW-1:0] rd_addr;
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [PW-1:0] mem_wlo, mem_whi;

  pgt_pkg::trim_res_t trim;

  logic [PW-1:0] sub_a, sub_b;
  logic [PW:0]   diff;
  logic          gap_ok;
  logic          have_two;
  logic          keep;

  pgt_trim_unit u_trim (
    .gap_lo (rd_lo_r),
    .gap_hi (rd_hi_r),
    .bar_lo (bar_lo_r),
    .bar_hi (bar_hi_r),
    .res    (trim)
  );

  // shared subtract and compare for the gap test
  assign sub_a    = (st_r == ST_DET_UP) ? bar_lo_r : older_low_r;
  assign sub_b    = (st_r == ST_DET_UP) ? older_high_r : bar_hi_r;
  assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
  assign gap_ok   = !diff[PW] && (diff[PW-1:0] > min_height_r);
  assign have_two = bars_seen_r[1];
  assign keep     = ev_valid_r && !trim.cancel;
  assign rd_addr  = cnt_r[SW-1:0];

  assign in_ready         = (st_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_new_gap      = out_gap_r;
  assign out_new_gap_low  = out_lo_r;
  assign out_new_gap_high = out_hi_r;
  assign out_new_gap_time = out_time_r;
  assign out_cancelled    = out_cancel_r;
  assign out_open_gaps    = out_open_r;
  assign out_overflow     = out_ovf_r;

  always_comb begin
    st_nxt         = st_r;
    min_height_nxt = cfg_wr_en ? cfg_wr_data : min_height_r;
    older_high_nxt = older_high_r;
    older_low_nxt  = older_low_r;
    prior_high_nxt = prior_high_r;
    prior_low_nxt  = prior_low_r;
    prior_time_nxt = prior_time_r;
    bars_seen_nxt  = bars_seen_r;
    bar_hi_nxt     = bar_hi_r;
    bar_lo_nxt     = bar_lo_r;
    bar_time_nxt   = bar_time_r;
    gap_valid_nxt  = gap_valid_r;
    cnt_nxt        = cnt_r;
    ev_en_nxt      = 1'b0;
    ev_valid_nxt   = 1'b0;
    ev_idx_nxt     = rd_addr;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    cancel_cnt_nxt = cancel_cnt_r;
    open_cnt_nxt   = open_cnt_r;
    kind_nxt       = kind_r;
    nlo_nxt        = nlo_r;
    nhi_nxt        = nhi_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_gap_nxt    = out_gap_r;
    out_lo_nxt     = out_lo_r;
    out_hi_nxt     = out_hi_r;
    out_time_nxt   = out_time_r;
    out_cancel_nxt = out_cancel_r;
    out_open_nxt   = out_open_r;
    out_ovf_nxt    = out_ovf_r;
    mem_we         = 1'b0;
    mem_waddr      = ev_idx_r;
    mem_wlo        = trim.lo;
    mem_whi        = trim.hi;

    // write back of the slot read in the previous cycle
    if (ev_en_r) begin
      if (ev_valid_r) begin
        mem_we = 1'b1;
        if (trim.cancel) begin
          gap_valid_nxt[ev_idx_r] = 1'b0;
          cancel_cnt_nxt          = cancel_cnt_r + 1'b1;
        end
      end
      if (keep) begin
        open_cnt_nxt = open_cnt_r + 1'b1;
      end else if (!free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = ev_idx_r;
      end
    end

    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          bar_hi_nxt     = in_bar_high;
          bar_lo_nxt     = in_bar_low;
          bar_time_nxt   = in_bar_time;
          cnt_nxt        = '0;
          free_found_nxt = 1'b0;
          cancel_cnt_nxt = '0;
          open_cnt_nxt   = '0;
          kind_nxt       = pgt_pkg::GAP_NONE;
          nlo_nxt        = '0;
          nhi_nxt        = '0;
          ovf_nxt        = 1'b0;
          st_nxt         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == SCAN_END) begin
          st_nxt = ST_DET_UP;
        end else begin
          ev_en_nxt    = 1'b1;
          ev_valid_nxt = gap_valid_r[rd_addr];
          cnt_nxt      = cnt_r + 1'b1;
        end
      end
      ST_DET_UP: begin
        if (have_two && gap_ok) begin
          kind_nxt = pgt_pkg::GAP_UP;
          nlo_nxt  = older_high_r;
          nhi_nxt  = bar_lo_r;
          st_nxt   = ST_INSERT;
        end else begin
          st_nxt = ST_DET_DN;
        end
      end
      ST_DET_DN: begin
        if (have_two && gap_ok) begin
          kind_nxt = pgt_pkg::GAP_DOWN;
          nlo_nxt  = bar_hi_r;
          nhi_nxt  = older_low_r;
          st_nxt   = ST_INSERT;
        end else begin
          st_nxt = ST_FINISH;
        end
      end
      ST_INSERT: begin
        if (free_found_r) begin
          mem_we                    = 1'b1;
          mem_waddr                 = free_idx_r;
          mem_wlo                   = nlo_r;
          mem_whi                   = nhi_r;
          gap_valid_nxt[free_idx_r] = 1'b1;
          open_cnt_nxt              = open_cnt_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
        st_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_gap_nxt    = kind_r;
          out_lo_nxt     = nlo_r;
          out_hi_nxt     = nhi_r;
          out_time_nxt   = (kind_r == pgt_pkg::GAP_NONE) ? '0 : prior_time_r;
          out_cancel_nxt = cancel_cnt_r;
          out_open_nxt   = open_cnt_r;
          out_ovf_nxt    = ovf_r;
          older_high_nxt = prior_high_r;
          older_low_nxt  = prior_low_r;
          prior_high_nxt = bar_hi_r;
          prior_low_nxt  = bar_lo_r;
          prior_time_nxt = bar_time_r;
          if (!have_two) begin
            bars_seen_nxt = bars_seen_r + 1'b1;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      min_height_r <= '0;
      older_high_r <= '0;
      older_low_r  <= '0;
      prior_high_r <= '0;
      prior_low_r  <= '0;
      prior_time_r <= '0;
      bars_seen_r  <= '0;
      gap_valid_r  <= '0;
      cnt_r        <= '0;
      ev_en_r      <= 1'b0;
      ev_valid_r   <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      min_height_r <= min_height_nxt;
      older_high_r <= older_high_nxt;
      older_low_r  <= older_low_nxt;
      prior_high_r <= prior_high_nxt;
      prior_low_r  <= prior_low_nxt;
      prior_time_r <= prior_time_nxt;
      bars_seen_r  <= bars_seen_nxt;
      gap_valid_r  <= gap_valid_nxt;
      cnt_r        <= cnt_nxt;
      ev_en_r      <= ev_en_nxt;
      ev_valid_r   <= ev_valid_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    bar_hi_r     <= bar_hi_nxt;
    bar_lo_r     <= bar_lo_nxt;
    bar_time_r   <= bar_time_nxt;
    ev_idx_r     <= ev_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    cancel_cnt_r <= cancel_cnt_nxt;
    open_cnt_r   <= open_cnt_nxt;
    kind_r       <= kind_nxt;
    nlo_r        <= nlo_nxt;
    nhi_r        <= nhi_nxt;
    ovf_r        <= ovf_nxt;
    out_gap_r    <= out_gap_nxt;
    out_lo_r     <= out_lo_nxt;
    out_hi_r     <= out_hi_nxt;
    out_time_r   <= out_time_nxt;
    out_cancel_r <= out_cancel_nxt;
    out_open_r   <= out_open_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  // gap table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      gap_lo_mem[mem_waddr] <= mem_wlo;
      gap_hi_mem[mem_waddr] <= mem_whi;
    end
    rd_lo_r <= gap_lo_mem[rd_addr];
    rd_hi_r <= gap_hi_mem[rd_addr];
  end

endmodule
`default_nettype wire
